// ===== design/lidar_polar_to_world_filter_defines.svh =====
// Assertion macros shared by the filter RTL.
// The macros pick up clk and rst_n from the module that uses them.
`ifndef LIDAR_POLAR_TO_WORLD_FILTER_DEFINES_SVH
`define LIDAR_POLAR_TO_WORLD_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define LPWF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpwf: same-cycle check failed");
`define LPWF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpwf: next-cycle check failed");
`else
`define LPWF_ASSERT_IMP(lbl, ante, cons)
`define LPWF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/lpwf_pkg.sv =====
package lpwf_pkg;

    localparam int TRIG_FRAC_BITS = 16;
    localparam int REL_FRAC       = 8;
    localparam int NUM_CELLS      = 7;

    // action codes
    localparam logic [1:0] ACT_POSE   = 2'd0;
    localparam logic [1:0] ACT_POINT  = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // register indexes
    localparam logic [2:0] REG_LIMIT_X_LOW    = 3'd0;
    localparam logic [2:0] REG_LIMIT_X_HIGH   = 3'd1;
    localparam logic [2:0] REG_LIMIT_Y_LOW    = 3'd2;
    localparam logic [2:0] REG_LIMIT_Y_HIGH   = 3'd3;
    localparam logic [2:0] REG_BORDER_MARGIN  = 3'd4;
    localparam logic [2:0] REG_MOUNT_OFFSET_X = 3'd5;
    localparam logic [2:0] REG_MOUNT_OFFSET_Y = 3'd6;

    localparam logic [15:0] ANG_FULL = 16'd36000;
    localparam logic [15:0] ANG_Q1   = 16'd9000;
    localparam logic [15:0] ANG_Q2   = 16'd18000;
    localparam logic [15:0] ANG_Q3   = 16'd27000;
    localparam logic [31:0] RAD_K44  = 32'd3070415691;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

    // derived widths
    localparam int TW       = TRIG_FRAC_BITS + 2;      // trig magnitude
    localparam int TSW      = TW + 1;                  // signed trig
    localparam int PW       = TSW + 17;                // distance * trig
    localparam int RW       = 28;                      // sensor-relative Q8 mm
    localparam int MW       = RW + TSW;                // rotation product
    localparam int GW       = MW + 2;                  // world sum
    localparam int TRIG_SH  = 30 - TRIG_FRAC_BITS;
    localparam int REL_SH   = TRIG_FRAC_BITS - REL_FRAC;
    localparam int SCALE_SH = REL_FRAC + TRIG_FRAC_BITS;

    localparam logic [31:0] RND_TRIG = 32'(64'd1 << (TRIG_SH - 1));
    localparam logic signed [PW-1:0] RND_REL = PW'(64'd1 << (REL_SH - 1));
    localparam logic signed [GW-1:0] RND_OUT = GW'(64'd1 << (SCALE_SH - 1));

    // Horner step divisors k*(k-1) and floor(2^32/d) per cell
    localparam logic [7:0] COS_DIV [NUM_CELLS] =
        '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] COS_RCP [NUM_CELLS] = '{
        32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd2)};
    // first sine entry is a don't-care: that cell passes one through
    localparam logic [7:0] SIN_DIV [NUM_CELLS] =
        '{8'd156, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] SIN_RCP [NUM_CELLS] = '{
        32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd6)};

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        point_angle;
        logic [15:0]        point_distance;
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic [15:0]        pose_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] world_x;
        logic signed [15:0] world_y;
        logic               end_of_scan;
    } out_item_t;

    // sideband riding the pipe; index 0 point angle, index 1 heading
    typedef struct packed {
        logic               is_end;
        logic [15:0]        rng;
        logic [1:0][1:0]    quad;
        logic signed [15:0] rob_x;
        logic signed [15:0] rob_y;
        logic [1:0][30:0]   x;
    } meta_t;

    typedef struct packed {
        logic [1:0][31:0] x2;
        logic [1:0][30:0] ts;
        logic [1:0][30:0] tc;
    } series_t;

    typedef struct packed {
        logic        sin_skip;
        logic [7:0]  sin_div;
        logic [31:0] sin_rcp;
        logic [7:0]  cos_div;
        logic [31:0] cos_rcp;
    } cell_cfg_t;

    typedef struct packed {
        logic signed [17:0] lo_x;
        logic signed [17:0] hi_x;
        logic signed [17:0] lo_y;
        logic signed [17:0] hi_y;
    } window_t;

endpackage

// ===== design/lpwf_front.sv =====
// Angle reduction, radian conversion and squaring for both angles.
module lpwf_front
    import lpwf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               load,
    input  logic               is_end,
    input  logic [15:0]        angle,
    input  logic [15:0]        range_mm,
    input  logic [15:0]        heading,
    input  logic signed [15:0] rob_x,
    input  logic signed [15:0] rob_y,
    output logic               out_valid,
    output meta_t              out_meta,
    output series_t            out_ser
);

    function automatic logic [15:0] ang_split(input logic [15:0] ang);
        logic [15:0] a;
        logic [1:0]  q;
        logic [15:0] r;
        a = (ang >= ANG_FULL) ? ang - ANG_FULL : ang;
        priority if (a >= ANG_Q3)
        begin
            q = 2'd3;
            r = a - ANG_Q3;
        end
        else if (a >= ANG_Q2)
        begin
            q = 2'd2;
            r = a - ANG_Q2;
        end
        else if (a >= ANG_Q1)
        begin
            q = 2'd1;
            r = a - ANG_Q1;
        end
        else
        begin
            q = 2'd0;
            r = a;
        end
        return {q, r[13:0]};
    endfunction

    logic             v0_reg, v1_reg, v2_reg;
    meta_t            meta0_reg, meta1_reg, meta2_reg;
    meta_t            meta0_next, meta1_next;
    logic [1:0][13:0] r0_reg;
    logic [1:0][13:0] r0_next;
    logic [1:0][31:0] x2_reg;
    logic [1:0][31:0] x2_next;
    logic [15:0]      sp_pt, sp_hd;
    logic [45:0]      xk [2];
    logic [61:0]      sq [2];

    always_comb
    begin
        sp_pt = ang_split(angle);
        sp_hd = ang_split(heading);
        meta0_next        = '0;
        meta0_next.is_end = is_end;
        meta0_next.rng    = range_mm;
        meta0_next.quad   = {sp_hd[15:14], sp_pt[15:14]};
        meta0_next.rob_x  = rob_x;
        meta0_next.rob_y  = rob_y;
        r0_next           = {sp_hd[13:0], sp_pt[13:0]};
    end

    always_comb
    begin
        meta1_next = meta0_reg;
        for (int j = 0; j < 2; j++)
        begin
            xk[j] = 46'(r0_reg[j]) * 46'(RAD_K44) + 46'(14'h2000);
            meta1_next.x[j] = xk[j][44:14];
            sq[j] = 62'(meta1_reg.x[j]) * 62'(meta1_reg.x[j]);
            x2_next[j] = sq[j][61:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= load;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta0_reg <= meta0_next;
            r0_reg    <= r0_next;
            meta1_reg <= meta1_next;
            meta2_reg <= meta1_reg;
            x2_reg    <= x2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_meta  = meta2_reg;
    always_comb
    begin
        out_ser.x2 = x2_reg;
        out_ser.ts = {ONE_Q30, ONE_Q30};
        out_ser.tc = {ONE_Q30, ONE_Q30};
    end

endmodule

// ===== design/lpwf_cell.sv =====
// One Horner step t = 1 - x2*t/(k(k-1)) for four series, three stages.
module lpwf_cell
    import lpwf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  cell_cfg_t cfg,
    input  logic      in_valid,
    input  meta_t     in_meta,
    input  series_t   in_ser,
    output logic      out_valid,
    output meta_t     out_meta,
    output series_t   out_ser
);

    function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [30:0] t);
        logic [62:0] m;
        m = 63'(a) * 63'(t);
        return m[61:30];
    endfunction

    function automatic logic [31:0] mul_rcp(input logic [31:0] p, input logic [31:0] rcp);
        logic [63:0] m;
        m = 64'(p) * 64'(rcp);
        return m[63:32];
    endfunction

    // reciprocal estimate is at most one low; fix it, then 1 - q clamped at 0
    function automatic logic [30:0] step_done(input logic [31:0] p, input logic [31:0] q0,
                                              input logic [7:0] d);
        logic [39:0] rem;
        logic [31:0] q;
        rem = {8'd0, p} - 40'(q0) * 40'(d);
        q   = (rem >= 40'(d)) ? q0 + 32'd1 : q0;
        return (q >= 32'(ONE_Q30)) ? 31'd0 : ONE_Q30 - q[30:0];
    endfunction

    logic             va_reg, vb_reg, vc_reg;
    meta_t            meta_a_reg, meta_b_reg, meta_c_reg;
    logic [1:0][31:0] x2_a_reg, x2_b_reg;
    logic [1:0][31:0] ps_a_reg, pc_a_reg, ps_b_reg, pc_b_reg;
    logic [1:0][31:0] qs_b_reg, qc_b_reg;
    series_t          ser_c_reg;
    logic [1:0][31:0] ps_a_next, pc_a_next, qs_b_next, qc_b_next;
    series_t          ser_c_next;

    always_comb
    begin
        ser_c_next.x2 = x2_b_reg;
        for (int j = 0; j < 2; j++)
        begin
            ps_a_next[j] = mul_q30(in_ser.x2[j], in_ser.ts[j]);
            pc_a_next[j] = mul_q30(in_ser.x2[j], in_ser.tc[j]);
            qs_b_next[j] = mul_rcp(ps_a_reg[j], cfg.sin_rcp);
            qc_b_next[j] = mul_rcp(pc_a_reg[j], cfg.cos_rcp);
            ser_c_next.ts[j] = cfg.sin_skip ? ONE_Q30
                             : step_done(ps_b_reg[j], qs_b_reg[j], cfg.sin_div);
            ser_c_next.tc[j] = step_done(pc_b_reg[j], qc_b_reg[j], cfg.cos_div);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_a_reg <= in_meta;
            x2_a_reg   <= in_ser.x2;
            ps_a_reg   <= ps_a_next;
            pc_a_reg   <= pc_a_next;
            meta_b_reg <= meta_a_reg;
            x2_b_reg   <= x2_a_reg;
            ps_b_reg   <= ps_a_reg;
            pc_b_reg   <= pc_a_reg;
            qs_b_reg   <= qs_b_next;
            qc_b_reg   <= qc_b_next;
            meta_c_reg <= meta_b_reg;
            ser_c_reg  <= ser_c_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_meta  = meta_c_reg;
    assign out_ser   = ser_c_reg;

endmodule

// ===== design/lpwf_back.sv =====
// Sine finish, rounding, quadrant fold, offset, rotation, window test.
module lpwf_back
    import lpwf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  meta_t              in_meta,
    input  series_t            in_ser,
    input  logic signed [11:0] off_x,
    input  logic signed [11:0] off_y,
    input  window_t            win,
    output logic               res_valid,
    output out_item_t          res
);

    function automatic logic [2*TSW-1:0] quad_map(input logic [1:0] q,
                                                  input logic [TW-1:0] s,
                                                  input logic [TW-1:0] c);
        logic signed [TSW-1:0] ps, pc;
        logic [2*TSW-1:0]      r;
        ps = signed'({1'b0, s});
        pc = signed'({1'b0, c});
        unique case (q)
            2'd0:    r = {ps, pc};
            2'd1:    r = {pc, -ps};
            2'd2:    r = {-ps, -pc};
            default: r = {-pc, ps};
        endcase
        return r;
    endfunction

    function automatic logic signed [GW-1:0] scale_bound(input logic signed [17:0] b);
        return {{(GW - 18 - SCALE_SH){b[17]}}, b, {SCALE_SH{1'b0}}};
    endfunction

    function automatic logic [15:0] sat16(input logic signed [GW-1:0] v);
        logic [15:0] r;
        priority if (v > GW'(32767))
            r = 16'h7fff;
        else if (v < -GW'(32768))
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    meta_t m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;

    logic [1:0][30:0]       sv1_reg, cv1_reg, sv1_next;
    logic signed [TSW-1:0]  sn2_reg [2], cs2_reg [2], sn2_next [2], cs2_next [2];
    logic signed [PW-1:0]   pcx3_reg, pcy3_reg, pcx3_next, pcy3_next;
    logic signed [TSW-1:0]  sh3_reg, ch3_reg, sh4_reg, ch4_reg;
    logic signed [RW-1:0]   rx4_reg, ry4_reg, rx4_next, ry4_next;
    logic signed [MW-1:0]   mxc5_reg, mys5_reg, mxs5_reg, myc5_reg;
    logic signed [GW-1:0]   gx6_reg, gy6_reg, gx6_next, gy6_next;

    logic [61:0]            sprod [2];
    logic [31:0]            srnd [2], crnd [2];
    logic [2*TSW-1:0]       mapped [2];
    logic signed [PW-1:0]   rndx, rndy, shx, shy;
    logic signed [GW-1:0]   bx, by, rwx, rwy, rsx, rsy;
    logic                   in_win;

    // stage 1 and 2: sine = x*t, round to trig format, fold quadrant
    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            sprod[j]    = 62'(in_meta.x[j]) * 62'(in_ser.ts[j]);
            sv1_next[j] = sprod[j][60:30];
            srnd[j]     = 32'(sv1_reg[j]) + RND_TRIG;
            crnd[j]     = 32'(cv1_reg[j]) + RND_TRIG;
            mapped[j]   = quad_map(m1_reg.quad[j], srnd[j][TRIG_SH +: TW],
                                   crnd[j][TRIG_SH +: TW]);
            sn2_next[j] = mapped[j][2*TSW-1:TSW];
            cs2_next[j] = mapped[j][TSW-1:0];
        end
    end

    // stage 3 and 4: polar to sensor Q8, plus mount offset
    always_comb
    begin
        pcx3_next = PW'(signed'({1'b0, m2_reg.rng})) * PW'(cs2_reg[0]);
        pcy3_next = PW'(signed'({1'b0, m2_reg.rng})) * PW'(sn2_reg[0]);
        rndx      = pcx3_reg + RND_REL;
        rndy      = pcy3_reg + RND_REL;
        shx       = rndx >>> REL_SH;
        shy       = rndy >>> REL_SH;
        rx4_next  = shx[RW-1:0] + {{(RW - 20){off_x[11]}}, off_x, 8'd0};
        ry4_next  = shy[RW-1:0] + {{(RW - 20){off_y[11]}}, off_y, 8'd0};
    end

    // stage 6: rotate and translate, kept exact
    always_comb
    begin
        bx = {{(GW - 16 - SCALE_SH){m5_reg.rob_x[15]}}, m5_reg.rob_x, {SCALE_SH{1'b0}}};
        by = {{(GW - 16 - SCALE_SH){m5_reg.rob_y[15]}}, m5_reg.rob_y, {SCALE_SH{1'b0}}};
        gx6_next = bx + GW'(mxc5_reg) - GW'(mys5_reg);
        gy6_next = by + GW'(mxs5_reg) + GW'(myc5_reg);
    end

    // window test and final rounding straight off stage 6
    always_comb
    begin
        in_win = (scale_bound(win.lo_x) < gx6_reg) && (gx6_reg < scale_bound(win.hi_x)) &&
                 (scale_bound(win.lo_y) < gy6_reg) && (gy6_reg < scale_bound(win.hi_y));
        rwx = gx6_reg + RND_OUT;
        rwy = gy6_reg + RND_OUT;
        rsx = rwx >>> SCALE_SH;
        rsy = rwy >>> SCALE_SH;
        res_valid       = v6_reg && (m6_reg.is_end || in_win);
        res.end_of_scan = m6_reg.is_end;
        res.world_x     = m6_reg.is_end ? 16'sd0 : sat16(rsx);
        res.world_y     = m6_reg.is_end ? 16'sd0 : sat16(rsy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg   <= in_meta;
            sv1_reg  <= sv1_next;
            cv1_reg  <= in_ser.tc;
            m2_reg   <= m1_reg;
            sn2_reg  <= sn2_next;
            cs2_reg  <= cs2_next;
            m3_reg   <= m2_reg;
            pcx3_reg <= pcx3_next;
            pcy3_reg <= pcy3_next;
            sh3_reg  <= sn2_reg[1];
            ch3_reg  <= cs2_reg[1];
            m4_reg   <= m3_reg;
            rx4_reg  <= rx4_next;
            ry4_reg  <= ry4_next;
            sh4_reg  <= sh3_reg;
            ch4_reg  <= ch3_reg;
            m5_reg   <= m4_reg;
            mxc5_reg <= MW'(rx4_reg) * MW'(ch4_reg);
            mys5_reg <= MW'(ry4_reg) * MW'(sh4_reg);
            mxs5_reg <= MW'(rx4_reg) * MW'(sh4_reg);
            myc5_reg <= MW'(ry4_reg) * MW'(ch4_reg);
            m6_reg   <= m5_reg;
            gx6_reg  <= gx6_next;
            gy6_reg  <= gy6_next;
        end
    end

endmodule

// ===== design/lidar_polar_to_world_filter.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data  (in_item_t)
// out       output     out_valid / out_ready  out_data (out_item_t)
// cfg       input      cfg_wr_en              cfg_index, cfg_wdata
//
// One transaction per cycle while the output buffer is not full; a point or end
// item passes 31 registers on its way to out_data (3 front stages, 7 Horner
// cells of 3 stages each, 6 back stages, output buffer). Pose loads take effect
// at once. The whole pipe advances together; it stops only while the 2-entry
// output buffer is full. rst_n is asynchronous and clears valid bits, pose,
// configuration registers and the output buffer count.
`include "lidar_polar_to_world_filter_defines.svh"
module lidar_polar_to_world_filter
    import lpwf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // configuration registers
    logic signed [15:0] limit_x_low_reg, limit_x_high_reg;
    logic signed [15:0] limit_y_low_reg, limit_y_high_reg;
    logic [11:0]        border_margin_reg;
    logic signed [11:0] mount_offset_x_reg, mount_offset_y_reg;

    // robot pose
    logic signed [15:0] robot_x_reg, robot_y_reg;
    logic [15:0]        robot_heading_reg;

    logic en;
    logic in_acc;
    logic is_point, is_end, is_pose;

    // cell chain
    logic      chain_valid [NUM_CELLS + 1];
    meta_t     chain_meta  [NUM_CELLS + 1];
    series_t   chain_ser   [NUM_CELLS + 1];
    cell_cfg_t cell_cfg    [NUM_CELLS];

    window_t   win;
    logic      res_valid;
    out_item_t res;

    // output buffer, entry 0 is the head
    out_item_t e0_reg, e1_reg, e0_next, e1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;
    assign in_acc   = in_valid && in_ready;
    assign is_point = (in_data.action == ACT_POINT);
    assign is_end   = (in_data.action == ACT_END);
    assign is_pose  = (in_data.action == ACT_POSE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_low_reg    <= -16'sd32768;
            limit_x_high_reg   <= 16'sd32767;
            limit_y_low_reg    <= -16'sd32768;
            limit_y_high_reg   <= 16'sd32767;
            border_margin_reg  <= 12'd0;
            mount_offset_x_reg <= 12'sd0;
            mount_offset_y_reg <= 12'sd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LIMIT_X_LOW:    limit_x_low_reg    <= cfg_wdata;
                REG_LIMIT_X_HIGH:   limit_x_high_reg   <= cfg_wdata;
                REG_LIMIT_Y_LOW:    limit_y_low_reg    <= cfg_wdata;
                REG_LIMIT_Y_HIGH:   limit_y_high_reg   <= cfg_wdata;
                REG_BORDER_MARGIN:  border_margin_reg  <= cfg_wdata[11:0];
                REG_MOUNT_OFFSET_X: mount_offset_x_reg <= cfg_wdata[11:0];
                REG_MOUNT_OFFSET_Y: mount_offset_y_reg <= cfg_wdata[11:0];
                default:            ;
            endcase
        end
    end

    // a point accepted the cycle after a pose transaction sees the new pose
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x_reg       <= 16'sd0;
            robot_y_reg       <= 16'sd0;
            robot_heading_reg <= 16'd0;
        end
        else if (in_acc && is_pose)
        begin
            robot_x_reg       <= in_data.pose_x;
            robot_y_reg       <= in_data.pose_y;
            robot_heading_reg <= in_data.pose_heading;
        end
    end

    // shrunk window; an inverted window simply never passes a point
    always_comb
    begin
        win.lo_x = {{2{limit_x_low_reg[15]}},  limit_x_low_reg}  + {6'd0, border_margin_reg};
        win.hi_x = {{2{limit_x_high_reg[15]}}, limit_x_high_reg} - {6'd0, border_margin_reg};
        win.lo_y = {{2{limit_y_low_reg[15]}},  limit_y_low_reg}  + {6'd0, border_margin_reg};
        win.hi_y = {{2{limit_y_high_reg[15]}}, limit_y_high_reg} - {6'd0, border_margin_reg};
    end

    // action code 3 and pose items never enter the pipe
    lpwf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .load      (in_acc && (is_point || is_end)),
        .is_end    (is_end),
        .angle     (in_data.point_angle),
        .range_mm  (in_data.point_distance),
        .heading   (robot_heading_reg),
        .rob_x     (robot_x_reg),
        .rob_y     (robot_y_reg),
        .out_valid (chain_valid[0]),
        .out_meta  (chain_meta[0]),
        .out_ser   (chain_ser[0])
    );

    // cosine runs k = 14..2 over all cells, sine k = 13..3 from the second on
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        assign cell_cfg[i].sin_skip = (i == 0);
        assign cell_cfg[i].sin_div  = SIN_DIV[i];
        assign cell_cfg[i].sin_rcp  = SIN_RCP[i];
        assign cell_cfg[i].cos_div  = COS_DIV[i];
        assign cell_cfg[i].cos_rcp  = COS_RCP[i];

        lpwf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .cfg       (cell_cfg[i]),
            .in_valid  (chain_valid[i]),
            .in_meta   (chain_meta[i]),
            .in_ser    (chain_ser[i]),
            .out_valid (chain_valid[i + 1]),
            .out_meta  (chain_meta[i + 1]),
            .out_ser   (chain_ser[i + 1])
        );
    end

    lpwf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (chain_valid[NUM_CELLS]),
        .in_meta   (chain_meta[NUM_CELLS]),
        .in_ser    (chain_ser[NUM_CELLS]),
        .off_x     (mount_offset_x_reg),
        .off_y     (mount_offset_y_reg),
        .win       (win),
        .res_valid (res_valid),
        .res       (res)
    );

    // the last stage leaves only when the pipe advances
    assign push      = res_valid && en;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = e0_reg;

    always_comb
    begin
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        cnt_next = cnt_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    e0_next = res;
                else
                    e1_next = res;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                e0_next  = e1_reg;
                cnt_next = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                    e0_next = res;
                else
                begin
                    e0_next = e1_reg;
                    e1_next = res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    `LPWF_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg != 2'd3)
    `LPWF_ASSERT_NEXT(a_pose_load, in_valid && in_ready && in_data.action == ACT_POSE, robot_x_reg == $past(in_data.pose_x) && robot_heading_reg == $past(in_data.pose_heading))
    `LPWF_ASSERT_NEXT(a_full_holds, cnt_reg == 2'd2 && !out_ready, cnt_reg == 2'd2)
    `LPWF_ASSERT_IMP(a_end_zero, out_valid && out_data.end_of_scan, out_data.world_x == 16'sd0 && out_data.world_y == 16'sd0)

endmodule
